FILE: sv/assert_macros.svh
// assertion macros used by the ranker back-end rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TKFR_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tkfr assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TKFR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tkfr assertion failed");

`endif

FILE: sv/tkfr_pkg.sv
// shared types and fixed field widths of the top-k frequency ranker
// no dependencies; used by front, back and top level
package tkfr_pkg;

  localparam int EVENT_ID_W = 9;
  localparam int OUT_CNT_W  = 32;
  localparam int RANK_W     = 3;

  // one queued event as classified by the front end
  typedef struct packed {
    logic [EVENT_ID_W-1:0] event_id;
    logic                  in_range;
  } tkfr_item_t;

endpackage

FILE: sv/top_k_frequency_ranker_top.sv
// top level of the top-k frequency ranker: front end, event queue, back end
// depends on tkfr_pkg, tkfr_front, tkfr_back (and tkfr_ram below it)
//
//   channel  | ports                                  | beat
//   ---------+----------------------------------------+-------------------------
//   input    | in_valid, in_ready, in_event_id        | one event id
//   result   | out_valid, out_ready, out_in_top,      | count, rank and insert
//            | out_rank_position, out_event_count,    | flag of one event
//            | out_newly_added                        |
//
// an in-range event passes the back end in these steps: pop and count read,
// count write and list lookup, the move-up or insertion scan one slot per
// step, and loading of the result register
// out-of-range ids go through pop and result load only and report all zeros
// after reset the count ram is cleared one entry a cycle, all NUM_IDS entries; the
// two-entry queue takes events meanwhile, and a stalled result holds the back end
module top_k_frequency_ranker_top #(
  parameter int NUM_IDS     = 512,
  parameter int TOP_SLOTS   = 5,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tkfr_pkg::EVENT_ID_W-1:0]  in_event_id,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_in_top,
  output logic [tkfr_pkg::RANK_W-1:0]      out_rank_position,
  output logic [tkfr_pkg::OUT_CNT_W-1:0]   out_event_count,
  output logic                             out_newly_added
);

  import tkfr_pkg::*;

  logic       q_valid;
  logic       q_pop;
  tkfr_item_t q_item;

  tkfr_front #(
    .NUM_IDS (NUM_IDS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_event_id (in_event_id),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_item)
  );

  tkfr_back #(
    .NUM_IDS     (NUM_IDS),
    .TOP_SLOTS   (TOP_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_item            (q_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_in_top        (out_in_top),
    .out_rank_position (out_rank_position),
    .out_event_count   (out_event_count),
    .out_newly_added   (out_newly_added)
  );

endmodule

FILE: sv/tkfr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; holds the per-id count table
module tkfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: sv/tkfr_front.sv
// front end: accepts events, checks the id range, queues them for the back end
// depends on tkfr_pkg
module tkfr_front #(
  parameter int NUM_IDS = 512
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tkfr_pkg::EVENT_ID_W-1:0]    in_event_id,
  output logic                               q_valid,
  input  logic                               q_pop,
  output tkfr_pkg::tkfr_item_t               q_item
);

  import tkfr_pkg::*;

  tkfr_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  logic       pop;
  tkfr_item_t new_item;

  assign in_ready = (fill_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    new_item.event_id = in_event_id;
    new_item.in_range = ({{(32-EVENT_ID_W){1'b0}}, in_event_id} < 32'(NUM_IDS));
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

FILE: sv/tkfr_back.sv
// back end: count table update, ranked list maintenance and result register
// depends on tkfr_pkg, tkfr_ram and assert_macros.svh
`include "assert_macros.svh"
module tkfr_back #(
  parameter int NUM_IDS     = 512,
  parameter int TOP_SLOTS   = 5,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  output logic                             q_pop,
  input  tkfr_pkg::tkfr_item_t             q_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_in_top,
  output logic [tkfr_pkg::RANK_W-1:0]      out_rank_position,
  output logic [tkfr_pkg::OUT_CNT_W-1:0]   out_event_count,
  output logic                             out_newly_added
);

  import tkfr_pkg::*;

  localparam int AW     = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int SLOT_W = (TOP_SLOTS > 1) ? $clog2(TOP_SLOTS) : 1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_INC   = 6'b000100,
    S_MOVE  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DONE  = 6'b100000
  } back_state_t;

  back_state_t state_r, state_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [EVENT_ID_W-1:0]  cur_id_r, cur_id_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]      pos_r, pos_nxt;
  logic [SLOT_W-1:0]      scan_r, scan_nxt;
  logic                   in_top_r, in_top_nxt;
  logic                   added_r, added_nxt;

  logic [EVENT_ID_W-1:0]  top_ids_r [TOP_SLOTS];
  logic [EVENT_ID_W-1:0]  top_ids_nxt [TOP_SLOTS];
  logic [TOP_SLOTS-1:0]   top_valid_r, top_valid_nxt;
  logic [COUNT_WIDTH-1:0] top_cnt_r [TOP_SLOTS];
  logic [COUNT_WIDTH-1:0] top_cnt_nxt [TOP_SLOTS];

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_in_top_r, out_in_top_nxt;
  logic [RANK_W-1:0]      out_rank_r, out_rank_nxt;
  logic [OUT_CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic                   out_added_r, out_added_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  logic [EVENT_ID_W+AW-1:0]        q_id_ext;
  logic [EVENT_ID_W+AW-1:0]        cur_id_ext;
  logic [COUNT_WIDTH-1:0]          cnt_inc;
  logic                            hit;
  logic [SLOT_W-1:0]               hit_idx;
  logic [SLOT_W-1:0]               sel_idx;
  logic [COUNT_WIDTH-1:0]          sel_cnt;
  logic [COUNT_WIDTH+OUT_CNT_W-1:0] cnt_ext;
  logic [SLOT_W+RANK_W-1:0]        pos_ext;

  tkfr_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_IDS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign q_id_ext   = {{AW{1'b0}}, q_item.event_id};
  assign cur_id_ext = {{AW{1'b0}}, cur_id_r};
  assign cnt_inc    = (ram_rdata == {COUNT_WIDTH{1'b1}}) ? ram_rdata : ram_rdata + 1'b1;
  assign cnt_ext    = {{OUT_CNT_W{1'b0}}, cnt_r};
  assign pos_ext    = {{RANK_W{1'b0}}, pos_r};

  // first listed slot holding the current id
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < TOP_SLOTS; i++) begin
      if (!hit && top_valid_r[i] && (top_ids_r[i] == cur_id_r)) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  // the one slot compared this cycle: above the moving id, or the scan point
  always_comb begin
    if (state_r == S_MOVE) begin
      sel_idx = (pos_r == '0) ? '0 : pos_r - 1'b1;
    end else begin
      sel_idx = scan_r;
    end
    sel_cnt = top_valid_r[sel_idx] ? top_cnt_r[sel_idx] : '0;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cur_id_nxt     = cur_id_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    scan_nxt       = scan_r;
    in_top_nxt     = in_top_r;
    added_nxt      = added_r;
    top_ids_nxt    = top_ids_r;
    top_valid_nxt  = top_valid_r;
    top_cnt_nxt    = top_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_in_top_nxt = out_in_top_r;
    out_rank_nxt   = out_rank_r;
    out_cnt_nxt    = out_cnt_r;
    out_added_nxt  = out_added_r;
    ram_we         = 1'b0;
    ram_waddr      = clr_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = q_id_ext[AW-1:0];
    q_pop          = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_r == AW'(NUM_IDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          ram_re     = 1'b1;
          cur_id_nxt = q_item.event_id;
          cnt_nxt    = '0;
          pos_nxt    = '0;
          in_top_nxt = 1'b0;
          added_nxt  = 1'b0;
          // out-of-range ids leave the count table and the list alone and report zeros
          state_nxt  = q_item.in_range ? S_INC : S_DONE;
        end
      end
      S_INC: begin
        ram_we    = 1'b1;
        ram_waddr = cur_id_ext[AW-1:0];
        ram_wdata = cnt_inc;
        cnt_nxt   = cnt_inc;
        if (hit) begin
          pos_nxt              = hit_idx;
          in_top_nxt           = 1'b1;
          top_cnt_nxt[hit_idx] = cnt_inc;
          state_nxt            = S_MOVE;
        end else begin
          scan_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_MOVE: begin
        // bubble up past strictly smaller counts, one slot per cycle
        if ((pos_r != '0) && (sel_cnt < cnt_r)) begin
          top_ids_nxt[pos_r]   = top_ids_r[sel_idx];
          top_valid_nxt[pos_r] = top_valid_r[sel_idx];
          top_cnt_nxt[pos_r]   = top_cnt_r[sel_idx];
          top_ids_nxt[sel_idx]   = cur_id_r;
          top_valid_nxt[sel_idx] = 1'b1;
          top_cnt_nxt[sel_idx]   = cnt_r;
          pos_nxt = sel_idx;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (cnt_r > sel_cnt) begin
          for (int j = 1; j < TOP_SLOTS; j++) begin
            if (j > int'(scan_r)) begin
              top_ids_nxt[j]   = top_ids_r[j-1];
              top_valid_nxt[j] = top_valid_r[j-1];
              top_cnt_nxt[j]   = top_cnt_r[j-1];
            end
          end
          top_ids_nxt[scan_r]   = cur_id_r;
          top_valid_nxt[scan_r] = 1'b1;
          top_cnt_nxt[scan_r]   = cnt_r;
          pos_nxt    = scan_r;
          in_top_nxt = 1'b1;
          added_nxt  = 1'b1;
          state_nxt  = S_DONE;
        end else if (scan_r == SLOT_W'(TOP_SLOTS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_in_top_nxt = in_top_r;
          out_rank_nxt   = pos_ext[RANK_W-1:0];
          out_cnt_nxt    = cnt_ext[OUT_CNT_W-1:0];
          out_added_nxt  = added_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      top_valid_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TOP_SLOTS; i++) begin
        top_ids_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      top_valid_r <= top_valid_nxt;
      out_valid_r <= out_valid_nxt;
      top_ids_r   <= top_ids_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_id_r     <= cur_id_nxt;
    cnt_r        <= cnt_nxt;
    pos_r        <= pos_nxt;
    scan_r       <= scan_nxt;
    in_top_r     <= in_top_nxt;
    added_r      <= added_nxt;
    top_cnt_r    <= top_cnt_nxt;
    out_in_top_r <= out_in_top_nxt;
    out_rank_r   <= out_rank_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_added_r  <= out_added_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_in_top        = out_in_top_r;
  assign out_rank_position = out_rank_r;
  assign out_event_count   = out_cnt_r;
  assign out_newly_added   = out_added_r;

  // listed slots stay packed at the head of the list
  `TKFR_ASSERT_IMPL(a_valid_prefix, clk, rst_n, 1'b1, (top_valid_r & (top_valid_r + 1'b1)) == '0)
  // a fresh result only comes out of the done state
  `TKFR_ASSERT_IMPL(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_DONE)
  // an unlisted result carries no rank and no insertion
  `TKFR_ASSERT_IMPL(a_unlisted_zero, clk, rst_n, out_valid_r && !out_in_top_r, (out_rank_r == '0) && !out_added_r)
  // the clearing pass runs to its last entry before any event is served
  `TKFR_ASSERT_NEXT(a_clear_runs, clk, rst_n, (state_r == S_CLEAR) && (clr_r != AW'(NUM_IDS - 1)), state_r == S_CLEAR)

endmodule
